// ----- hdl/hpi_pkg.sv -----
// hpi_pkg: shared types, constants and the arctangent table for the
// harmonic product integral block; no dependencies
package hpi_pkg;

	localparam int TRIG_ITERATIONS = 24;
	localparam int HARMONIC_BITS   = 6;

	// fixed-point angle constants, Q.28 radians, and the cordic start gain, Q2.30
	localparam logic [31:0] TWO_PI_Q28     = 32'd1686629713;
	localparam logic [31:0] PI_Q28         = 32'd843314857;
	localparam logic [31:0] HALF_PI_Q28    = 32'd421657428;
	localparam logic [31:0] THIRD_TURN_Q28 = 32'd562209904;
	localparam logic [31:0] CORDIC_START   = 32'd652032874;

	// mode codes
	localparam logic [2:0] MODE_COS_A = 3'd0;
	localparam logic [2:0] MODE_COS_B = 3'd1;
	localparam logic [2:0] MODE_COS_C = 3'd2;
	localparam logic [2:0] MODE_SIN_A = 3'd3;
	localparam logic [2:0] MODE_SIN_B = 3'd4;
	localparam logic [2:0] MODE_SIN_C = 3'd5;

	// datapath widths and pipeline depths
	localparam int ANGLE_W    = 44;
	localparam int TRIG_W     = 34;
	localparam int RED_STEPS  = 31;
	localparam int TRIG_LAT   = TRIG_ITERATIONS + 34;
	localparam int DIV_W      = 33;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = DIV_W / DIV_STEP;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic signed [31:0] scale;
		logic [5:0]         kernel_harmonic;
		logic [5:0]         wave_order;
		logic signed [31:0] phase_angle;
	} item_t;

	typedef struct packed {
		logic signed [31:0] integral_value;
		logic               saturated;
		logic               zero_divisor;
	} result_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic               active;
		logic               zero_divisor;
		logic               sin_kernel;
		logic               equal;
		logic signed [7:0]  m_sum;
		logic signed [7:0]  m_dif;
		logic signed [31:0] xa;
		logic signed [31:0] xb;
		logic signed [31:0] k;
		logic signed [33:0] poff;
	} op_t;

	// sideband that travels alongside the trig lanes
	typedef struct packed {
		logic               valid;
		logic               active;
		logic               zero_divisor;
		logic               sin_kernel;
		logic               equal;
		logic signed [7:0]  m_sum;
		logic signed [7:0]  m_dif;
		logic signed [32:0] dx;
		logic signed [31:0] k;
	} side1_t;

	// sideband that travels alongside the dividers
	typedef struct packed {
		logic               valid;
		logic               active;
		logic               zero_divisor;
		logic               sin_kernel;
		logic               equal;
		logic               neg_sum;
		logic               neg_dif;
		logic signed [40:0] lin_term;
		logic signed [31:0] k;
	} side2_t;

	// atan(2^-i) in Q2.30
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		case (i)
			0: v = 32'd843314857;
			1: v = 32'd497837829;
			2: v = 32'd263043837;
			3: v = 32'd133525159;
			4: v = 32'd67021687;
			5: v = 32'd33543516;
			6: v = 32'd16775851;
			7: v = 32'd8388437;
			8: v = 32'd4194283;
			9: v = 32'd2097149;
			10: v = 32'd1048576;
			11: v = 32'd524288;
			12: v = 32'd262144;
			13: v = 32'd131072;
			14: v = 32'd65536;
			15: v = 32'd32768;
			16: v = 32'd16384;
			17: v = 32'd8192;
			18: v = 32'd4096;
			19: v = 32'd2048;
			20: v = 32'd1024;
			21: v = 32'd512;
			22: v = 32'd256;
			23: v = 32'd128;
			24: v = 32'd64;
			25: v = 32'd32;
			26: v = 32'd16;
			27: v = 32'd8;
			28: v = 32'd4;
			29: v = 32'd2;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/hpi_front.sv -----
// hpi_front: accepts transactions, classifies mode and harmonics, and
// buffers them in a two-entry queue; depends on hpi_pkg
module hpi_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  hpi_pkg::item_t item,
	output logic           busy,
	output logic           op_valid,
	output hpi_pkg::op_t   op
);
	import hpi_pkg::*;

	localparam logic [5:0] HMASK = 6'((1 << HARMONIC_BITS) - 1);

	logic [5:0]  n, t;
	logic        push, pop, no_harm;
	op_t         cls;
	op_t         mem_q [0:1];
	logic        wr_q, rd_q;
	logic [1:0]  count_q;

	// classification of the incoming transaction
	always_comb begin
		n       = item.kernel_harmonic & HMASK;
		t       = item.wave_order & HMASK;
		no_harm = (n == 6'd0) && (t == 6'd0);
		cls.sin_kernel = 1'b0;
		cls.poff       = 34'(item.phase_angle);
		cls.active     = 1'b1;
		case (item.mode)
			MODE_COS_A: ;
			MODE_COS_B: cls.poff = 34'(item.phase_angle) - 34'(THIRD_TURN_Q28);
			MODE_COS_C: cls.poff = 34'(item.phase_angle) + 34'(THIRD_TURN_Q28);
			MODE_SIN_A: cls.sin_kernel = 1'b1;
			MODE_SIN_B: begin
				cls.sin_kernel = 1'b1;
				cls.poff = 34'(item.phase_angle) - 34'(THIRD_TURN_Q28);
			end
			MODE_SIN_C: begin
				cls.sin_kernel = 1'b1;
				cls.poff = 34'(item.phase_angle) + 34'(THIRD_TURN_Q28);
			end
			default: cls.active = 1'b0;
		endcase
		cls.zero_divisor = cls.active && no_harm;
		cls.active       = cls.active && !no_harm;
		cls.equal        = (n == t);
		cls.m_sum        = $signed({2'b00, t} + {2'b00, n});
		cls.m_dif        = $signed({2'b00, t} - {2'b00, n});
		cls.xa           = item.lower_bound;
		cls.xb           = item.upper_bound;
		cls.k            = item.scale;
	end

	// queue control: the back end drains one entry per cycle
	assign busy     = (count_q == 2'd2);
	assign push     = start && !busy;
	assign pop      = (count_q != 2'd0);
	assign op_valid = pop;
	assign op       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- hdl/hpi_trig.sv -----
// hpi_trig: pipelined sine/cosine lane, modulo 2*pi reduction by restoring
// steps, quadrant fold and rotation cordic; depends on hpi_pkg
module hpi_trig (
	input  logic                               clk,
	input  logic signed [hpi_pkg::ANGLE_W-1:0] angle,
	input  logic                               want_sin,
	output logic signed [hpi_pkg::TRIG_W-1:0]  trig
);
	import hpi_pkg::*;

	localparam logic [45:0] REDUCE_BIAS = 46'(TWO_PI_Q28) << 13;

	logic [45:0] biased;
	logic [30:0] rem_s  [0:RED_STEPS];
	logic [30:0] low_s  [0:RED_STEPS];
	logic        wr_s   [0:RED_STEPS];

	logic signed [TRIG_W-1:0] x_s [0:TRIG_ITERATIONS];
	logic signed [TRIG_W-1:0] y_s [0:TRIG_ITERATIONS];
	logic signed [TRIG_W-1:0] z_s [0:TRIG_ITERATIONS];
	logic                     wc_s [0:TRIG_ITERATIONS];
	logic                     ng_s [0:TRIG_ITERATIONS];

	logic signed [32:0] fold_r;
	logic               fold_neg;
	logic signed [TRIG_W-1:0] pick;

	// bias to a positive value, keep the top bits as the first remainder
	assign biased = 46'(angle) + REDUCE_BIAS;

	always_ff @(posedge clk) begin
		rem_s[0] <= 31'(biased[44:31]);
		low_s[0] <= biased[30:0];
		wr_s[0]  <= want_sin;
	end

	// one restoring modulo step per stage
	for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
		logic [31:0] tmp;
		assign tmp = {rem_s[j], low_s[j][RED_STEPS-1-j]};
		always_ff @(posedge clk) begin
			rem_s[j+1] <= (tmp >= TWO_PI_Q28) ? 31'(tmp - TWO_PI_Q28) : tmp[30:0];
			low_s[j+1] <= low_s[j];
			wr_s[j+1]  <= wr_s[j];
		end
	end

	// fold into [-pi/2, pi/2]
	always_comb begin
		fold_r   = $signed({2'b00, rem_s[RED_STEPS]});
		fold_neg = 1'b0;
		if ({1'b0, rem_s[RED_STEPS]} > PI_Q28)
			fold_r = fold_r - $signed({1'b0, TWO_PI_Q28});
		if (fold_r > $signed({1'b0, HALF_PI_Q28})) begin
			fold_r   = fold_r - $signed({1'b0, PI_Q28});
			fold_neg = 1'b1;
		end else if (fold_r < -$signed({1'b0, HALF_PI_Q28})) begin
			fold_r   = fold_r + $signed({1'b0, PI_Q28});
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]  <= $signed(TRIG_W'(CORDIC_START));
		y_s[0]  <= '0;
		z_s[0]  <= TRIG_W'(fold_r) <<< 2;
		wc_s[0] <= wr_s[RED_STEPS];
		ng_s[0] <= fold_neg;
	end

	// rotation cordic, one micro-rotation per stage
	for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cordic
		localparam logic [TRIG_W-1:0] ATAN = TRIG_W'(atan_q30(i));
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed(ATAN);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed(ATAN);
			end
			wc_s[i+1] <= wc_s[i];
			ng_s[i+1] <= ng_s[i];
		end
	end

	// select and restore quadrant sign
	assign pick = wc_s[TRIG_ITERATIONS] ? y_s[TRIG_ITERATIONS] : x_s[TRIG_ITERATIONS];

	always_ff @(posedge clk) begin
		trig <= ng_s[TRIG_ITERATIONS] ? -pick : pick;
	end

endmodule

// ----- hdl/hpi_div.sv -----
// hpi_div: pipelined unsigned restoring divider, a few quotient bits per
// stage, narrow divisor; depends on hpi_pkg
module hpi_div (
	input  logic                       clk,
	input  logic [hpi_pkg::DIV_W-1:0]  dividend,
	input  logic [7:0]                 divisor,
	output logic [hpi_pkg::DIV_W-1:0]  quotient
);
	import hpi_pkg::*;

	logic [DIV_W-1:0] num_s [0:DIV_STAGES];
	logic [DIV_W-1:0] quo_s [0:DIV_STAGES];
	logic [7:0]       rem_s [0:DIV_STAGES];
	logic [7:0]       den_s [0:DIV_STAGES];

	assign num_s[0] = dividend;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign den_s[0] = divisor;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DIV_W-1:0] num, quo;
		logic [7:0]       rem;
		logic [8:0]       tmp;

		// restoring steps on the shifted-in dividend bits
		always_comb begin
			num = num_s[g];
			quo = quo_s[g];
			rem = rem_s[g];
			tmp = '0;
			for (int b = 0; b < DIV_STEP; b++) begin
				tmp = {rem, num[DIV_W-1]};
				num = num << 1;
				if (tmp >= {1'b0, den_s[g]}) begin
					rem = 8'(tmp - {1'b0, den_s[g]});
					quo = {quo[DIV_W-2:0], 1'b1};
				end else begin
					rem = tmp[7:0];
					quo = {quo[DIV_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			num_s[g+1] <= num;
			quo_s[g+1] <= quo;
			rem_s[g+1] <= rem;
			den_s[g+1] <= den_s[g];
		end
	end

	assign quotient = quo_s[DIV_STAGES];

endmodule

// ----- hdl/hpi_back.sv -----
// hpi_back: angle generation, four trig lanes, quotient dividers, linear
// term, scaling with rounding and saturation; depends on hpi_pkg, hpi_trig,
// hpi_div
module hpi_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  hpi_pkg::op_t     op,
	output logic             done,
	output hpi_pkg::result_t result
);
	import hpi_pkg::*;

	logic signed [ANGLE_W-1:0] ang_s1 [0:3];
	logic                      want_s1 [0:3];
	side1_t                    side_s1;
	logic signed [ANGLE_W-1:0] p_sa, p_sb, p_da, p_db;
	logic signed [TRIG_W-1:0]  trig [0:3];
	side1_t                    tl_q [0:TRIG_LAT-1];
	side1_t                    st;

	logic signed [34:0] d_sum, d_dif, a_sum, a_dif;
	logic signed [64:0] lin_prod;
	logic [DIV_W-1:0]   mag_sum_s2, mag_dif_s2, q_sum, q_dif;
	logic [7:0]         den_sum_s2, den_dif_s2;
	side2_t             side_s2;
	side2_t             dl_q [0:DIV_STAGES-1];
	side2_t             sd;

	logic signed [33:0] qs_s3;
	logic signed [41:0] term_s3;
	side2_t             side_s3;
	logic signed [41:0] sum_s4;
	side2_t             side_s4;
	logic [39:0]        abs_s5;
	logic [31:0]        absk_s5;
	logic               neg_s5, valid_s5, active_s5, zdiv_s5;
	logic [51:0]        phi_s6, plo_s6;
	logic               neg_s6, valid_s6, active_s6, zdiv_s6;
	logic [71:0]        full;
	logic [37:0]        mag_s7;
	logic               neg_s7, valid_s7, active_s7, zdiv_s7;

	// angle products: m * x * 16 + phase
	assign p_sa = (ANGLE_W'(op.m_sum) * ANGLE_W'(op.xa)) <<< 4;
	assign p_sb = (ANGLE_W'(op.m_sum) * ANGLE_W'(op.xb)) <<< 4;
	assign p_da = (ANGLE_W'(op.m_dif) * ANGLE_W'(op.xa)) <<< 4;
	assign p_db = (ANGLE_W'(op.m_dif) * ANGLE_W'(op.xb)) <<< 4;

	always_ff @(posedge clk) begin
		ang_s1[0]  <= p_sb + ANGLE_W'(op.poff);
		ang_s1[1]  <= p_sa + ANGLE_W'(op.poff);
		ang_s1[2]  <= p_db + ANGLE_W'(op.poff);
		ang_s1[3]  <= p_da + ANGLE_W'(op.poff);
		want_s1[0] <= op.sin_kernel;
		want_s1[1] <= op.sin_kernel;
		// equal harmonics: lane two evaluates the other function of the phase
		want_s1[2] <= op.equal ? !op.sin_kernel : op.sin_kernel;
		want_s1[3] <= op.sin_kernel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.valid        <= op_valid;
			side_s1.active       <= op.active;
			side_s1.zero_divisor <= op.zero_divisor;
			side_s1.sin_kernel   <= op.sin_kernel;
			side_s1.equal        <= op.equal;
			side_s1.m_sum        <= op.m_sum;
			side_s1.m_dif        <= op.m_dif;
			side_s1.dx           <= 33'(op.xb) - 33'(op.xa);
			side_s1.k            <= op.k;
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		hpi_trig u_trig (
			.clk      (clk),
			.angle    (ang_s1[l]),
			.want_sin (want_s1[l]),
			.trig     (trig[l])
		);
	end

	// sideband delay matching the trig lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRIG_LAT; i++)
				tl_q[i] <= '0;
		end else begin
			tl_q[0] <= side_s1;
			for (int i = 1; i < TRIG_LAT; i++)
				tl_q[i] <= tl_q[i-1];
		end
	end
	assign st = tl_q[TRIG_LAT-1];

	// trig differences, divisor magnitudes and the linear term
	always_comb begin
		d_sum    = 35'(trig[0]) - 35'(trig[1]);
		d_dif    = 35'(trig[2]) - 35'(trig[3]);
		a_sum    = d_sum[34] ? -d_sum : d_sum;
		a_dif    = d_dif[34] ? -d_dif : d_dif;
		lin_prod = 65'(trig[2] >>> 2) * 65'(st.dx);
	end

	always_ff @(posedge clk) begin
		mag_sum_s2 <= a_sum[DIV_W-1:0];
		mag_dif_s2 <= a_dif[DIV_W-1:0];
		den_sum_s2 <= 8'({st.m_sum, 1'b0});
		den_dif_s2 <= st.m_dif[7] ? 8'({-st.m_dif, 1'b0}) : 8'({st.m_dif, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2.valid        <= st.valid;
			side_s2.active       <= st.active;
			side_s2.zero_divisor <= st.zero_divisor;
			side_s2.sin_kernel   <= st.sin_kernel;
			side_s2.equal        <= st.equal;
			side_s2.neg_sum      <= d_sum[34];
			side_s2.neg_dif      <= d_dif[34] ^ st.m_dif[7];
			side_s2.lin_term     <= 41'(lin_prod >>> 23);
			side_s2.k            <= st.k;
		end
	end

	hpi_div u_div_sum (
		.clk      (clk),
		.dividend (mag_sum_s2),
		.divisor  (den_sum_s2),
		.quotient (q_sum)
	);

	hpi_div u_div_dif (
		.clk      (clk),
		.dividend (mag_dif_s2),
		.divisor  (den_dif_s2),
		.quotient (q_dif)
	);

	// sideband delay matching the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++)
				dl_q[i] <= '0;
		end else begin
			dl_q[0] <= side_s2;
			for (int i = 1; i < DIV_STAGES; i++)
				dl_q[i] <= dl_q[i-1];
		end
	end
	assign sd = dl_q[DIV_STAGES-1];

	// signed quotients and the second term
	always_ff @(posedge clk) begin
		qs_s3 <= sd.neg_sum ? -$signed({1'b0, q_sum}) : $signed({1'b0, q_sum});
		if (sd.equal)
			term_s3 <= 42'(sd.lin_term);
		else if (sd.sin_kernel ^ sd.neg_dif)
			term_s3 <= 42'($signed({1'b0, q_dif}));
		else
			term_s3 <= -42'($signed({1'b0, q_dif}));
	end

	// integral sum
	always_ff @(posedge clk) begin
		sum_s4 <= term_s3 - 42'(qs_s3);
	end

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		abs_s5  <= sum_s4[41] ? 40'(-sum_s4) : sum_s4[39:0];
		absk_s5 <= side_s4.k[31] ? 32'(-33'(side_s4.k)) : side_s4.k;
		neg_s5  <= sum_s4[41] != side_s4.k[31];
	end

	// split product of the sum by the scale
	always_ff @(posedge clk) begin
		phi_s6 <= 52'(abs_s5[39:20]) * 52'(absk_s5);
		plo_s6 <= 52'(abs_s5[19:0]) * 52'(absk_s5);
		neg_s6 <= neg_s5;
	end

	// round half away from zero to Q12.20
	assign full = (72'(phi_s6) << 20) + 72'(plo_s6) + (72'd1 << 33);

	always_ff @(posedge clk) begin
		mag_s7 <= full[71:34];
		neg_s7 <= neg_s6;
	end

	// control through the scaling stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3   <= '0;
			side_s4   <= '0;
			valid_s5  <= 1'b0;
			active_s5 <= 1'b0;
			zdiv_s5   <= 1'b0;
			valid_s6  <= 1'b0;
			active_s6 <= 1'b0;
			zdiv_s6   <= 1'b0;
			valid_s7  <= 1'b0;
			active_s7 <= 1'b0;
			zdiv_s7   <= 1'b0;
		end else begin
			side_s3   <= sd;
			side_s4   <= side_s3;
			valid_s5  <= side_s4.valid;
			active_s5 <= side_s4.active;
			zdiv_s5   <= side_s4.zero_divisor;
			valid_s6  <= valid_s5;
			active_s6 <= active_s5;
			zdiv_s6   <= zdiv_s5;
			valid_s7  <= valid_s6;
			active_s7 <= active_s6;
			zdiv_s7   <= zdiv_s6;
		end
	end

	// saturation and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			result <= '0;
		end else begin
			done                <= valid_s7;
			result.zero_divisor <= zdiv_s7;
			result.saturated    <= 1'b0;
			result.integral_value <= '0;
			if (active_s7) begin
				if (!neg_s7) begin
					if (mag_s7 > 38'h7FFFFFFF) begin
						result.integral_value <= 32'sh7FFFFFFF;
						result.saturated      <= 1'b1;
					end else begin
						result.integral_value <= $signed(mag_s7[31:0]);
					end
				end else begin
					if (mag_s7 > 38'h80000000) begin
						result.integral_value <= 32'sh80000000;
						result.saturated      <= 1'b1;
					end else begin
						result.integral_value <= $signed(32'(-mag_s7));
					end
				end
			end
		end
	end

endmodule

// ----- hdl/harmonic_product_integral.sv -----
// harmonic_product_integral: top level, front classifier and queue feeding
// the pipelined back end; depends on hpi_pkg, hpi_front, hpi_back
//
// Usage:
//   A transaction is taken on a rising edge where start is high and busy is
//   low; item carries mode, bounds, scale, harmonics and phase.
//   Each transaction gives exactly one result: done is high for one cycle
//   with result holding integral_value, saturated and zero_divisor.
//   Results leave in the order transactions were taken.
//   Throughput: one transaction per cycle, sustained.
//   From the accepting edge to done a transaction passes the 31-step
//   modulo 2*pi reduction, the cordic stages of the four trig lanes and
//   the quotient dividers.
//   The back end never stalls and drains one queue entry per cycle, so the
//   queue never holds more than one entry and busy stays low; the receiver
//   cannot hold results off and must take each one.
//   Reset clears the queue and all pipeline valid bits; no result is
//   produced for transactions in flight at reset.
//   Unused modes give zero with no flags; zero harmonics give zero with
//   zero_divisor set.
module harmonic_product_integral (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hpi_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output hpi_pkg::result_t result
);
	import hpi_pkg::*;

	logic op_valid;
	op_t  op;

	hpi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.op_valid (op_valid),
		.op       (op)
	);

	hpi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.done     (done),
		.result   (result)
	);

endmodule
